FILE: rtl/nsf_pkg.sv
package nsf_pkg;

    localparam int NAME_LEN      = 5;
    localparam int NAME_LEN_W    = 3;
    localparam int COUNT_W       = 6;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    localparam logic [COUNT_W-1:0]    COUNT_MAX    = 6'd63;
    localparam logic [NAME_LEN_W-1:0] NAME_FULL    = 3'd5;
    localparam logic [NAME_LEN_W-1:0] NAME_OVER    = 3'd6;

    localparam logic [8*NAME_LEN-1:0] NAME_GPGGA = "GPGGA";
    localparam logic [8*NAME_LEN-1:0] NAME_GPRMC = "GPRMC";
    localparam logic [8*NAME_LEN-1:0] NAME_GPGSA = "GPGSA";
    localparam logic [8*NAME_LEN-1:0] NAME_GPGSV = "GPGSV";

    typedef enum logic [2:0] {
        KIND_UNKNOWN = 3'd0,
        KIND_GPGGA   = 3'd1,
        KIND_GPRMC   = 3'd2,
        KIND_GPGSA   = 3'd3,
        KIND_GPGSV   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        VERDICT_ACCEPTED   = 3'd0,
        VERDICT_NO_DOLLAR  = 3'd1,
        VERDICT_BAD_SUFFIX = 3'd2,
        VERDICT_MISMATCH   = 3'd3,
        VERDICT_EMPTY      = 3'd4,
        VERDICT_FEW_FIELDS = 3'd5
    } verdict_t;

    typedef enum logic [1:0] {
        TOK_FIRST = 2'd0,
        TOK_BODY  = 2'd1,
        TOK_END   = 2'd2
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t  kind;
        logic [7:0] data;
        logic       is_dollar;
        logic       is_star;
        logic       is_comma;
        logic       hex_ok;
        logic [3:0] hex_val;
    } token_t;

    function automatic logic [COUNT_W-1:0] min_fields(kind_t k);
        logic [COUNT_W-1:0] m;
        m = '0;
        unique case (k)
            KIND_GPGGA: m = 6'd13;
            KIND_GPRMC: m = 6'd12;
            KIND_GPGSA: m = 6'd3;
            KIND_GPGSV: m = 6'd4;
            default:    m = '0;
        endcase
        return m;
    endfunction

endpackage

FILE: rtl/nsf_if.sv
interface nsf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nsf_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] sentence_kind;
    logic [2:0] verdict;
    logic       checksum_present;
    logic [7:0] computed_checksum;
    logic [5:0] field_count;

    modport source (output valid, output sentence_kind, output verdict,
                    output checksum_present, output computed_checksum,
                    output field_count, input ready);
    modport sink   (input valid, input sentence_kind, input verdict,
                    input checksum_present, input computed_checksum,
                    input field_count, output ready);
endinterface

FILE: rtl/nmea_sentence_framer_unit.sv
// channel  | role   | payload
// ---------+--------+---------------------------------------------------------
// rx       | sink   | rx_byte[7:0]
// result   | source | sentence_kind[2:0] verdict[2:0] checksum_present
//          |        | computed_checksum[7:0] field_count[5:0]
//
// One byte is taken every cycle while the queue has room; the front classifies
// it and the back updates the line state off a four-entry token queue.
// A result leaves from an output register that is loaded when the back
// pops its terminator, and the queue keeps bytes flowing while it waits.
// A stalled result holds the back only on the next line end; rx.ready
// drops once the queue is full. Reset (rst_n, async) returns to between lines.
module nmea_sentence_framer_unit (
    input  logic         clk,
    input  logic         rst_n,
    nsf_byte_if.sink     rx,
    nsf_result_if.source result
);

    logic            push_valid;
    nsf_pkg::token_t push_token;
    logic            queue_full;
    logic            tok_valid;
    nsf_pkg::token_t tok;
    logic            pop;

    nsf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .push_valid (push_valid),
        .push_token (push_token),
        .queue_full (queue_full)
    );

    nsf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push_valid),
        .push_token (push_token),
        .full       (queue_full),
        .pop_valid  (tok_valid),
        .pop_token  (tok),
        .pop        (pop)
    );

    nsf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .tok       (tok),
        .pop       (pop),
        .result    (result)
    );

endmodule

FILE: rtl/nsf_front.sv
module nsf_front (
    input  logic            clk,
    input  logic            rst_n,
    nsf_byte_if.sink        rx,
    output logic            push_valid,
    output nsf_pkg::token_t push_token,
    input  logic            queue_full
);

    logic line_open_reg;
    logic line_open_next;
    logic is_term;
    logic accept;
    logic [7:0] b;

    assign b        = rx.rx_byte;
    assign is_term  = (b == nsf_pkg::CH_CR) || (b == nsf_pkg::CH_LF);
    assign rx.ready = !queue_full;
    assign accept   = rx.valid && !queue_full;

    // drop terminators that fall between lines
    assign push_valid = rx.valid && !(is_term && !line_open_reg);

    always_comb
    begin
        push_token.data      = b;
        push_token.is_dollar = (b == nsf_pkg::CH_DOLLAR);
        push_token.is_star   = (b == nsf_pkg::CH_STAR);
        push_token.is_comma  = (b == nsf_pkg::CH_COMMA);
        push_token.hex_ok    = 1'b1;
        push_token.hex_val   = '0;
        priority if (b >= "0" && b <= "9")
            push_token.hex_val = 4'(b - 8'h30);
        else if (b >= "A" && b <= "F")
            push_token.hex_val = 4'(b - 8'h37);
        else if (b >= "a" && b <= "f")
            push_token.hex_val = 4'(b - 8'h57);
        else
            push_token.hex_ok = 1'b0;

        priority if (is_term)
            push_token.kind = nsf_pkg::TOK_END;
        else if (!line_open_reg)
            push_token.kind = nsf_pkg::TOK_FIRST;
        else
            push_token.kind = nsf_pkg::TOK_BODY;
    end

    always_comb
    begin
        line_open_next = line_open_reg;
        if (accept)
            line_open_next = !is_term;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            line_open_reg <= 1'b0;
        else
            line_open_reg <= line_open_next;
    end

endmodule

FILE: rtl/nsf_queue.sv
module nsf_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  nsf_pkg::token_t push_token,
    output logic            full,
    output logic            pop_valid,
    output nsf_pkg::token_t pop_token,
    input  logic            pop
);

    localparam logic [nsf_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
        nsf_pkg::QUEUE_PTR_W'(nsf_pkg::QUEUE_DEPTH - 1);
    localparam logic [nsf_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
        nsf_pkg::QUEUE_CNT_W'(nsf_pkg::QUEUE_DEPTH);

    nsf_pkg::token_t slots [nsf_pkg::QUEUE_DEPTH];

    logic [nsf_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [nsf_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [nsf_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign pop_valid = (count_reg != '0);
    assign pop_token = slots[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots[wr_ptr_reg] <= push_token;
    end

endmodule

FILE: rtl/nsf_back.sv
module nsf_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            tok_valid,
    input  nsf_pkg::token_t tok,
    output logic            pop,
    nsf_result_if.source    result
);

    logic                                starts_dollar_reg, starts_dollar_next;
    logic                                after_star_reg, after_star_next;
    logic [7:0]                          xor_reg, xor_next;
    logic [1:0]                          suffix_len_reg, suffix_len_next;
    logic [7:0]                          suffix_val_reg, suffix_val_next;
    logic                                suffix_bad_reg, suffix_bad_next;
    logic [nsf_pkg::COUNT_W-1:0]         comma_cnt_reg, comma_cnt_next;
    logic                                last_comma_reg, last_comma_next;
    logic                                nonempty_reg, nonempty_next;
    logic [nsf_pkg::NAME_LEN_W-1:0]      name_len_reg, name_len_next;
    logic [7:0]                          name_chars [nsf_pkg::NAME_LEN];
    logic                                name_wr;

    logic                                out_valid_reg, out_valid_next;
    nsf_pkg::kind_t                      out_kind_reg;
    nsf_pkg::verdict_t                   out_verdict_reg;
    logic                                out_present_reg;
    logic [7:0]                          out_xor_reg;
    logic [nsf_pkg::COUNT_W-1:0]         out_fields_reg;

    logic                                res_load;
    logic                                is_end;
    nsf_pkg::kind_t                      fin_kind;
    nsf_pkg::verdict_t                   fin_verdict;
    logic [nsf_pkg::COUNT_W-1:0]         fin_fields;
    logic [8*nsf_pkg::NAME_LEN-1:0]      name_word;

    // a line end waits until the output register is free
    assign is_end = (tok.kind == nsf_pkg::TOK_END);
    assign pop    = tok_valid && (!is_end || !out_valid_reg || result.ready);

    always_comb
    begin
        starts_dollar_next = starts_dollar_reg;
        after_star_next    = after_star_reg;
        xor_next           = xor_reg;
        suffix_len_next    = suffix_len_reg;
        suffix_val_next    = suffix_val_reg;
        suffix_bad_next    = suffix_bad_reg;
        comma_cnt_next     = comma_cnt_reg;
        last_comma_next    = last_comma_reg;
        nonempty_next      = nonempty_reg;
        name_len_next      = name_len_reg;
        name_wr            = 1'b0;
        res_load           = 1'b0;
        if (pop)
        begin
            unique case (tok.kind)
                nsf_pkg::TOK_FIRST:
                begin
                    starts_dollar_next = tok.is_dollar;
                end
                nsf_pkg::TOK_BODY:
                begin
                    if (starts_dollar_reg)
                    begin
                        priority if (after_star_reg)
                        begin
                            if (suffix_len_reg >= 2'd2 || !tok.hex_ok)
                                suffix_bad_next = 1'b1;
                            else
                                suffix_val_next = {suffix_val_reg[3:0], tok.hex_val};
                            if (suffix_len_reg != 2'd3)
                                suffix_len_next = suffix_len_reg + 1'b1;
                        end
                        else if (tok.is_star)
                        begin
                            after_star_next = 1'b1;
                        end
                        else
                        begin
                            xor_next      = xor_reg ^ tok.data;
                            nonempty_next = 1'b1;
                            if (tok.is_comma)
                            begin
                                if (comma_cnt_reg != nsf_pkg::COUNT_MAX)
                                    comma_cnt_next = comma_cnt_reg + 1'b1;
                                last_comma_next = 1'b1;
                            end
                            else
                            begin
                                last_comma_next = 1'b0;
                                if (comma_cnt_reg == '0)
                                begin
                                    name_wr = (name_len_reg < nsf_pkg::NAME_FULL);
                                    if (name_len_reg < nsf_pkg::NAME_OVER)
                                        name_len_next = name_len_reg + 1'b1;
                                end
                            end
                        end
                    end
                end
                nsf_pkg::TOK_END:
                begin
                    res_load           = 1'b1;
                    starts_dollar_next = 1'b0;
                    after_star_next    = 1'b0;
                    xor_next           = '0;
                    suffix_len_next    = '0;
                    suffix_val_next    = '0;
                    suffix_bad_next    = 1'b0;
                    comma_cnt_next     = '0;
                    last_comma_next    = 1'b0;
                    nonempty_next      = 1'b0;
                    name_len_next      = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // kind, field count and verdict of the line that is closing
    always_comb
    begin
        name_word = {name_chars[0], name_chars[1], name_chars[2],
                     name_chars[3], name_chars[4]};
        fin_kind = nsf_pkg::KIND_UNKNOWN;
        if (name_len_reg == nsf_pkg::NAME_FULL)
        begin
            priority if (name_word == nsf_pkg::NAME_GPGGA)
                fin_kind = nsf_pkg::KIND_GPGGA;
            else if (name_word == nsf_pkg::NAME_GPRMC)
                fin_kind = nsf_pkg::KIND_GPRMC;
            else if (name_word == nsf_pkg::NAME_GPGSA)
                fin_kind = nsf_pkg::KIND_GPGSA;
            else if (name_word == nsf_pkg::NAME_GPGSV)
                fin_kind = nsf_pkg::KIND_GPGSV;
            else
                fin_kind = nsf_pkg::KIND_UNKNOWN;
        end

        fin_fields = '0;
        if (nonempty_reg)
        begin
            fin_fields = comma_cnt_reg;
            if (!last_comma_reg && comma_cnt_reg != nsf_pkg::COUNT_MAX)
                fin_fields = comma_cnt_reg + 1'b1;
        end

        priority if (!starts_dollar_reg)
            fin_verdict = nsf_pkg::VERDICT_NO_DOLLAR;
        else if (after_star_reg && (suffix_len_reg != 2'd2 || suffix_bad_reg))
            fin_verdict = nsf_pkg::VERDICT_BAD_SUFFIX;
        else if (after_star_reg && suffix_val_reg != xor_reg)
            fin_verdict = nsf_pkg::VERDICT_MISMATCH;
        else if (fin_fields == '0 || fin_kind == nsf_pkg::KIND_UNKNOWN)
            fin_verdict = nsf_pkg::VERDICT_EMPTY;
        else if (fin_fields < nsf_pkg::min_fields(fin_kind))
            fin_verdict = nsf_pkg::VERDICT_FEW_FIELDS;
        else
            fin_verdict = nsf_pkg::VERDICT_ACCEPTED;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            starts_dollar_reg <= 1'b0;
            after_star_reg    <= 1'b0;
            xor_reg           <= '0;
            suffix_len_reg    <= '0;
            suffix_val_reg    <= '0;
            suffix_bad_reg    <= 1'b0;
            comma_cnt_reg     <= '0;
            last_comma_reg    <= 1'b0;
            nonempty_reg      <= 1'b0;
            name_len_reg      <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            starts_dollar_reg <= starts_dollar_next;
            after_star_reg    <= after_star_next;
            xor_reg           <= xor_next;
            suffix_len_reg    <= suffix_len_next;
            suffix_val_reg    <= suffix_val_next;
            suffix_bad_reg    <= suffix_bad_next;
            comma_cnt_reg     <= comma_cnt_next;
            last_comma_reg    <= last_comma_next;
            nonempty_reg      <= nonempty_next;
            name_len_reg      <= name_len_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < nsf_pkg::NAME_LEN; k++)
        begin
            if (name_wr && name_len_reg == nsf_pkg::NAME_LEN_W'(k))
                name_chars[k] <= tok.data;
        end
        if (res_load)
        begin
            out_verdict_reg <= fin_verdict;
            if (starts_dollar_reg)
            begin
                out_kind_reg    <= fin_kind;
                out_present_reg <= after_star_reg;
                out_xor_reg     <= xor_reg;
                out_fields_reg  <= fin_fields;
            end
            else
            begin
                out_kind_reg    <= nsf_pkg::KIND_UNKNOWN;
                out_present_reg <= 1'b0;
                out_xor_reg     <= '0;
                out_fields_reg  <= '0;
            end
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.sentence_kind     = out_kind_reg;
    assign result.verdict           = out_verdict_reg;
    assign result.checksum_present  = out_present_reg;
    assign result.computed_checksum = out_xor_reg;
    assign result.field_count       = out_fields_reg;

    a_no_dollar_blank: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_verdict_reg == nsf_pkg::VERDICT_NO_DOLLAR
        |-> out_kind_reg == nsf_pkg::KIND_UNKNOWN && out_fields_reg == '0
            && out_xor_reg == '0 && !out_present_reg)
        else $error("no-dollar result carries body data");

    a_accept_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_verdict_reg == nsf_pkg::VERDICT_ACCEPTED
        |-> out_kind_reg != nsf_pkg::KIND_UNKNOWN && out_fields_reg != '0)
        else $error("accepted line without kind or fields");

    a_star_needs_dollar: assert property (@(posedge clk) disable iff (!rst_n)
        after_star_reg |-> starts_dollar_reg)
        else $error("suffix tracked on a line without dollar");

    a_long_suffix_bad: assert property (@(posedge clk) disable iff (!rst_n)
        suffix_len_reg == 2'd3 |-> suffix_bad_reg)
        else $error("over-long suffix not flagged");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> !after_star_reg && comma_cnt_reg == '0 && name_len_reg == '0
                     && out_valid_reg)
        else $error("line state not cleared at line end");

endmodule
